// ===== rtl/hpsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsp_pkg
// Shared codes and field widths for the heap page swap policy block.
// ----------------------------------------------------------------------------
package hpsp_pkg;

   localparam int ADDR_W   = 39;
   localparam int PAGE_SH  = 12;
   localparam int PN_W     = ADDR_W - PAGE_SH;
   localparam int TICK_W   = 32;
   localparam int IDX_W    = 4;
   localparam int BLK_W    = 10;
   localparam int STAT_W   = 3;
   localparam int CNT_W    = 5;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_FAULT    = 1'b1;

   localparam logic [STAT_W-1:0] ST_FRESH    = 3'd0;
   localparam logic [STAT_W-1:0] ST_SWAP     = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_HEAP = 3'd2;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd3;
   localparam logic [STAT_W-1:0] ST_REG      = 3'd4;

   localparam logic [CSR_IW-1:0] CSR_MAX_RES = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_AGE     = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_WSET    = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

   typedef logic [PN_W-1:0]   page_num_type;
   typedef logic [TICK_W-1:0] tick_type;

endpackage

// ===== rtl/heap_page_swap_policy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_page_swap_policy
// Working set page replacement with oldest-load fallback over a small heap
// page table and a swap block bitmap, run by one sequencer.
//
// channel   ports                         direction
// request   start, busy, req_*            in (busy out)
// response  rsp_valid, rsp_*              out
// control   csr_we, csr_index, csr_wdata  in
//
// a register word writes its table entry, then frees the entry's old blocks if swapped
// a fault looks the page up over up to TABLE_ENTRIES entries, then when at the limit
// scans the bitmap for a free run (one bit per cycle on the bitmap read port),
// scans TABLE_ENTRIES entries for a victim and makes up to 2*BLOCKS_PER_PAGE block writes
// after reset the whole bitmap is cleared with busy high
// rsp_valid is a one cycle strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module heap_page_swap_policy
   import hpsp_pkg::*;
#(
   parameter int TABLE_ENTRIES   = 16,
   parameter int SWAP_BLOCKS     = 1024,
   parameter int BLOCKS_PER_PAGE = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [ADDR_W-1:0] req_fault_addr,
   input  logic [TICK_W-1:0] req_now,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [IDX_W-1:0]  rsp_heap_index,
   output logic              rsp_evicted_valid,
   output logic [ADDR_W-1:0] rsp_evicted_addr,
   output logic [BLK_W-1:0]  rsp_evict_block,
   output logic [BLK_W-1:0]  rsp_retrieve_block,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int BW = (SWAP_BLOCKS > 1) ? $clog2(SWAP_BLOCKS) : 1;
   localparam int PW = $clog2(BLOCKS_PER_PAGE + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_REG   = 4'd2;
   localparam logic [3:0] S_LOOK  = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_RUN   = 4'd5;
   localparam logic [3:0] S_VSCAN = 4'd6;
   localparam logic [3:0] S_VUPD  = 4'd7;
   localparam logic [3:0] S_MARK  = 4'd8;
   localparam logic [3:0] S_LOAD  = 4'd9;
   localparam logic [3:0] S_FREE  = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   localparam logic [TW-1:0] PTR_LAST = TW'(TABLE_ENTRIES - 1);
   localparam logic [PW-1:0] BLK_LAST = PW'(BLOCKS_PER_PAGE - 1);
   localparam logic [BW:0]   NBLK     = (BW+1)'(SWAP_BLOCKS);
   localparam logic [BW-1:0] BLK_END  = BW'(SWAP_BLOCKS - 1);

   // control
   logic [3:0]       state_ff, state_in;
   logic [TW-1:0]    ptr_ff, ptr_in;
   logic [BW:0]      cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [BW-1:0]    pidx_ff, pidx_in;
   logic [PW-1:0]    runlen_ff, runlen_in;
   logic [PW-1:0]    bcnt_ff, bcnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wsf_ff, wsf_in;
   logic             fb_ff, fb_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] max_ff, max_in;
   logic [TICK_W-1:0] thr_ff, thr_in;
   logic             wset_ff, wset_in;
   logic             tvld_ff [TABLE_ENTRIES];
   logic             tvld_in [TABLE_ENTRIES];
   logic             tld_ff  [TABLE_ENTRIES];
   logic             tld_in  [TABLE_ENTRIES];
   logic             tsv_ff  [TABLE_ENTRIES];
   logic             tsv_in  [TABLE_ENTRIES];

   // payload
   page_num_type     tpn_ff   [TABLE_ENTRIES];
   page_num_type     tpn_in   [TABLE_ENTRIES];
   tick_type         ttick_ff [TABLE_ENTRIES];
   tick_type         ttick_in [TABLE_ENTRIES];
   logic [BW-1:0]    tsb_ff   [TABLE_ENTRIES];
   logic [BW-1:0]    tsb_in   [TABLE_ENTRIES];
   logic             op_ff, op_in;
   logic             inr_ff, inr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   page_num_type     rpn_ff, rpn_in;
   tick_type         now_ff, now_in;
   logic [TW-1:0]    h_ff, h_in;
   logic [TW-1:0]    wsv_ff, wsv_in;
   logic [TW-1:0]    fv_ff, fv_in;
   logic [TICK_W:0]  least_ff, least_in;
   logic [BW-1:0]    start_ff, start_in;
   logic [BW-1:0]    run_ff, run_in;
   logic [BW-1:0]    base_ff, base_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [IDX_W-1:0] hidx_ff, hidx_in;
   logic             evv_ff, evv_in;
   logic [ADDR_W-1:0] eva_ff, eva_in;
   logic [BLK_W-1:0] evb_ff, evb_in;
   logic [BLK_W-1:0] rtb_ff, rtb_in;

   // swap block bitmap
   logic             blk_used_mem [SWAP_BLOCKS];
   logic             blk_q_ff;
   logic             mem_we;
   logic [BW-1:0]    mem_waddr;
   logic             mem_wdata;
   logic [BW-1:0]    mem_raddr;

   logic [BW:0]      blk_sum;
   logic             wsf_n, fb_n;
   logic [TW-1:0]    wsv_n, fv_n;
   logic [TICK_W-1:0] age;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         blk_used_mem[mem_waddr] <= mem_wdata;
      end
      blk_q_ff <= blk_used_mem[mem_raddr];
   end

   always_comb begin
      blk_sum = {1'b0, (state_ff == S_MARK) ? run_ff : base_ff} + (BW+1)'(bcnt_ff);
      age     = now_ff - ttick_ff[ptr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      runlen_in    = runlen_ff;
      bcnt_in      = bcnt_ff;
      count_in     = count_ff;
      wsf_in       = wsf_ff;
      fb_in        = fb_ff;
      rsp_valid_in = 1'b0;
      max_in       = max_ff;
      thr_in       = thr_ff;
      wset_in      = wset_ff;
      tvld_in      = tvld_ff;
      tld_in       = tld_ff;
      tsv_in       = tsv_ff;
      tpn_in       = tpn_ff;
      ttick_in     = ttick_ff;
      tsb_in       = tsb_ff;
      op_in        = op_ff;
      inr_in       = inr_ff;
      idx_in       = idx_ff;
      rpn_in       = rpn_ff;
      now_in       = now_ff;
      h_in         = h_ff;
      wsv_in       = wsv_ff;
      fv_in        = fv_ff;
      least_in     = least_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      base_in      = base_ff;
      st_in        = st_ff;
      hidx_in      = hidx_ff;
      evv_in       = evv_ff;
      eva_in       = eva_ff;
      evb_in       = evb_ff;
      rtb_in       = rtb_ff;
      mem_we       = 1'b0;
      mem_waddr    = blk_sum[BW-1:0];
      mem_wdata    = 1'b0;
      mem_raddr    = cnt_ff[BW-1:0];
      wsf_n        = wsf_ff;
      wsv_n        = wsv_ff;
      fb_n         = fb_ff;
      fv_n         = fv_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RES: max_in  = csr_wdata[CNT_W-1:0];
            CSR_AGE:     thr_in  = csr_wdata[TICK_W-1:0];
            CSR_WSET:    wset_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[BW-1:0];
            mem_wdata = 1'b0;
            if (cnt_ff[BW-1:0] == BLK_END) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_op;
               idx_in  = req_entry_index;
               rpn_in  = req_fault_addr[ADDR_W-1:PAGE_SH];
               now_in  = req_now;
               st_in   = ST_FRESH;
               hidx_in = '0;
               evv_in  = 1'b0;
               eva_in  = '0;
               evb_in  = '0;
               rtb_in  = '0;
               if (req_op == OP_REGISTER) begin
                  ptr_in   = TW'(req_entry_index);
                  inr_in   = (32'(req_entry_index) < 32'(TABLE_ENTRIES));
                  state_in = S_REG;
               end else begin
                  ptr_in   = '0;
                  state_in = S_LOOK;
               end
            end
         end
         S_REG: begin
            st_in    = ST_REG;
            hidx_in  = idx_ff;
            state_in = S_DONE;
            if (inr_ff) begin
               if (tld_ff[ptr_ff] && count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               tpn_in[ptr_ff]   = rpn_ff;
               tvld_in[ptr_ff]  = 1'b1;
               tld_in[ptr_ff]   = 1'b0;
               ttick_in[ptr_ff] = '0;
               tsv_in[ptr_ff]   = 1'b0;
               if (tsv_ff[ptr_ff]) begin
                  base_in  = tsb_ff[ptr_ff];
                  bcnt_in  = '0;
                  state_in = S_FREE;
               end
            end
         end
         S_LOOK: begin
            if (tvld_ff[ptr_ff] && tpn_ff[ptr_ff] == rpn_ff) begin
               h_in     = ptr_ff;
               state_in = S_CHECK;
            end else if (ptr_ff == PTR_LAST) begin
               st_in    = ST_NOT_HEAP;
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_CHECK: begin
            hidx_in = IDX_W'(h_ff);
            if (count_ff >= max_ff) begin
               cnt_in    = '0;
               pend_in   = 1'b0;
               runlen_in = '0;
               state_in  = S_RUN;
            end else begin
               ptr_in   = h_ff;
               state_in = S_LOAD;
            end
         end
         S_RUN: begin
            if (cnt_ff < NBLK) begin
               pend_in = 1'b1;
               pidx_in = cnt_ff[BW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (blk_q_ff) begin
                  runlen_in = '0;
               end else begin
                  if (runlen_ff == '0) begin
                     start_in = pidx_ff;
                  end
                  if (({1'b0, runlen_ff} + 1'b1) == (PW+1)'(BLOCKS_PER_PAGE)) begin
                     run_in   = (runlen_ff == '0) ? pidx_ff : start_ff;
                     ptr_in   = '0;
                     wsf_in   = 1'b0;
                     fb_in    = 1'b0;
                     least_in = {1'b0, now_ff} + 1'b1;
                     state_in = S_VSCAN;
                  end else begin
                     runlen_in = runlen_ff + 1'b1;
                  end
               end
               if (state_in != S_VSCAN && pidx_ff == BLK_END) begin
                  st_in    = ST_NO_SPACE;
                  ptr_in   = h_ff;
                  state_in = S_LOAD;
               end
            end
         end
         S_VSCAN: begin
            if (tld_ff[ptr_ff]) begin
               if (wset_ff && !wsf_ff && age > thr_ff) begin
                  wsf_n = 1'b1;
                  wsv_n = ptr_ff;
               end
               if ({1'b0, ttick_ff[ptr_ff]} < least_ff) begin
                  fb_n     = 1'b1;
                  fv_n     = ptr_ff;
                  least_in = {1'b0, ttick_ff[ptr_ff]};
               end
            end
            wsf_in = wsf_n;
            wsv_in = wsv_n;
            fb_in  = fb_n;
            fv_in  = fv_n;
            if (ptr_ff == PTR_LAST) begin
               if (wsf_n) begin
                  ptr_in   = wsv_n;
                  state_in = S_VUPD;
               end else if (fb_n) begin
                  ptr_in   = fv_n;
                  state_in = S_VUPD;
               end else begin
                  ptr_in   = h_ff;
                  state_in = S_LOAD;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_VUPD: begin
            tld_in[ptr_ff] = 1'b0;
            tsv_in[ptr_ff] = 1'b1;
            tsb_in[ptr_ff] = run_ff;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            evv_in   = 1'b1;
            eva_in   = {tpn_ff[ptr_ff], {PAGE_SH{1'b0}}};
            evb_in   = BLK_W'(run_ff);
            bcnt_in  = '0;
            state_in = S_MARK;
         end
         S_MARK: begin
            mem_we    = (blk_sum < NBLK);
            mem_wdata = 1'b1;
            if (bcnt_ff == BLK_LAST) begin
               ptr_in   = h_ff;
               state_in = S_LOAD;
            end else begin
               bcnt_in = bcnt_ff + 1'b1;
            end
         end
         S_LOAD: begin
            ttick_in[ptr_ff] = now_ff;
            state_in         = S_FIN;
            if (tsv_ff[ptr_ff]) begin
               rtb_in         = BLK_W'(tsb_ff[ptr_ff]);
               base_in        = tsb_ff[ptr_ff];
               tsv_in[ptr_ff] = 1'b0;
               if (st_ff != ST_NO_SPACE) begin
                  st_in = ST_SWAP;
               end
               bcnt_in  = '0;
               state_in = S_FREE;
            end
         end
         S_FREE: begin
            mem_we    = (blk_sum < NBLK);
            mem_wdata = 1'b0;
            if (bcnt_ff == BLK_LAST) begin
               state_in = (op_ff == OP_REGISTER) ? S_DONE : S_FIN;
            end else begin
               bcnt_in = bcnt_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (!tld_ff[ptr_ff]) begin
               tld_in[ptr_ff] = 1'b1;
               if (count_ff < CNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         runlen_ff    <= '0;
         bcnt_ff      <= '0;
         count_ff     <= '0;
         wsf_ff       <= 1'b0;
         fb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= 5'd4;
         thr_ff       <= 32'd10;
         wset_ff      <= 1'b1;
         ptr_ff       <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tvld_ff[i] <= 1'b0;
            tld_ff[i]  <= 1'b0;
            tsv_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         runlen_ff    <= runlen_in;
         bcnt_ff      <= bcnt_in;
         count_ff     <= count_in;
         wsf_ff       <= wsf_in;
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         thr_ff       <= thr_in;
         wset_ff      <= wset_in;
         ptr_ff       <= ptr_in;
         tvld_ff      <= tvld_in;
         tld_ff       <= tld_in;
         tsv_ff       <= tsv_in;
      end
   end

   always_ff @(posedge clock) begin
      tpn_ff   <= tpn_in;
      ttick_ff <= ttick_in;
      tsb_ff   <= tsb_in;
      op_ff    <= op_in;
      inr_ff   <= inr_in;
      idx_ff   <= idx_in;
      rpn_ff   <= rpn_in;
      now_ff   <= now_in;
      h_ff     <= h_in;
      wsv_ff   <= wsv_in;
      fv_ff    <= fv_in;
      least_ff <= least_in;
      start_ff <= start_in;
      run_ff   <= run_in;
      base_ff  <= base_in;
      pidx_ff  <= pidx_in;
      st_ff    <= st_in;
      hidx_ff  <= hidx_in;
      evv_ff   <= evv_in;
      eva_ff   <= eva_in;
      evb_ff   <= evb_in;
      rtb_ff   <= rtb_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = st_ff;
   assign rsp_heap_index     = hidx_ff;
   assign rsp_evicted_valid  = evv_ff;
   assign rsp_evicted_addr   = eva_ff;
   assign rsp_evict_block    = evb_ff;
   assign rsp_retrieve_block = rtb_ff;

endmodule

// ===== rtl/hpsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsp_checker
// Port level checks for the heap page swap policy block.
// ----------------------------------------------------------------------------
module hpsp_checker
   import hpsp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [STAT_W-1:0] rsp_status,
   input logic [IDX_W-1:0]  rsp_heap_index,
   input logic              rsp_evicted_valid,
   input logic [ADDR_W-1:0] rsp_evicted_addr,
   input logic [BLK_W-1:0]  rsp_evict_block
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word held for more than one cycle");

   a_not_heap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_HEAP |->
         !rsp_evicted_valid && rsp_heap_index == '0)
      else $error("not heap result carries data");

   a_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |->
         rsp_evicted_addr == '0 && rsp_evict_block == '0)
      else $error("eviction fields set without eviction");

endmodule

bind heap_page_swap_policy hpsp_checker u_hpsp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_heap_index    (rsp_heap_index),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_addr  (rsp_evicted_addr),
   .rsp_evict_block   (rsp_evict_block)
);
